### hw/rtl/stack_with_remove_by_value_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef STACK_WITH_REMOVE_BY_VALUE_CORE_ASSERT_SVH
`define STACK_WITH_REMOVE_BY_VALUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWRBV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWRBV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/swrbv_pkg.sv
package swrbv_pkg;

    localparam int DEPTH = 32;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W = 6;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } t_res;

    // One access slot of the entry store: one write and one read per cycle.
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_POP    = 4'b0010,
        S_SEARCH = 4'b0100,
        S_SHIFT  = 4'b1000
    } t_state;

endpackage

### hw/rtl/stack_with_remove_by_value_core.sv
// Bounded LIFO stack of signed 32-bit words with remove-by-value.
// Command channel: a beat is taken on a rising edge with start high and
// busy low; i_cmd carries the operation (push, pop, remove) and the value.
// Result channel: o_strobe is high for exactly one cycle per command, with
// o_result holding read value, status and occupancy after the command.
// The receiver cannot stall; every result is consumed on its strobe cycle.
// Path from start accept to strobe, by command:
//   push, empty pop, remove on empty, unused opcode: busy stays low
//   pop: one synchronous read of the entry store, then the answer
//   remove: search from the top down to the match (every entry if absent),
//   then each entry above the match is moved down one place.
// The entry store has one write and one registered read port; the search
// and the shift each move one entry per cycle through it, which sets the
// remove time. A new command may be started while the previous result is
// on the strobe. Reset (synchronous, active low) empties the stack; the
// store itself is not cleared, only entries below the count are ever read.
module stack_with_remove_by_value_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  swrbv_pkg::t_cmd  i_cmd,
    output logic             busy,
    output logic             o_strobe,
    output swrbv_pkg::t_res  o_result
);

    import swrbv_pkg::*;

    t_mem_req           mem_req;
    logic [DATA_W-1:0]  rd_data;
    logic               res_vld;
    t_res               res;
    logic               r_strobe;
    t_res               r_result;

    // Sequencer: search from the top, then shift entries down one per cycle.
    swrbv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .o_busy    (busy),
        .o_mem_req (mem_req),
        .i_rd_data (rd_data),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // Entry store. Reads and writes in one cycle never hit the same entry:
    // the shift writes entry j while reading j+2, and a push written on one
    // edge is read back no earlier than the next cycle.
    swrbv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    // Result register: one strobe beat per command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_result <= res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### hw/rtl/swrbv_ram.sv
module swrbv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/swrbv_ctrl.sv
module swrbv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  swrbv_pkg::t_cmd      i_cmd,
    output logic                 o_busy,
    output swrbv_pkg::t_mem_req  o_mem_req,
    input  logic [31:0]          i_rd_data,
    output logic                 o_res_vld,
    output swrbv_pkg::t_res      o_res
);

    import swrbv_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   r_idx, n_idx;
    logic [DATA_W-1:0]  r_val, n_val;
    t_mem_req           req;
    logic               res_vld;
    t_res               res;
    logic               full, empty;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_val   = r_val;
        req     = '0;
        res_vld = 1'b0;
        res     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val = i_cmd.value;
                    unique case (i_cmd.operation)
                        OP_PUSH: begin
                            res_vld = 1'b1;
                            if (full) begin
                                res.status = ST_FULL;
                            end else begin
                                req.we    = 1'b1;
                                req.waddr = PTR_W'(r_count);
                                req.wdata = i_cmd.value;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                res_vld    = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                req.re    = 1'b1;
                                req.raddr = PTR_W'(r_count - CNT_W'(1));
                                n_state   = S_POP;
                            end
                        end
                        OP_REMOVE: begin
                            if (empty) begin
                                res_vld    = 1'b1;
                                res.status = ST_NOT_FOUND;
                            end else begin
                                req.re    = 1'b1;
                                req.raddr = PTR_W'(r_count - CNT_W'(1));
                                n_idx     = PTR_W'(r_count - CNT_W'(1));
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            res_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                res_vld        = 1'b1;
                res.read_value = i_rd_data;
                n_count        = r_count - CNT_W'(1);
                n_state        = S_IDLE;
            end
            S_SEARCH: begin
                // read data belongs to entry r_idx
                if (i_rd_data == r_val) begin
                    if ((CNT_W'(r_idx) + CNT_W'(1)) < r_count) begin
                        req.re    = 1'b1;
                        req.raddr = r_idx + PTR_W'(1);
                        n_state   = S_SHIFT;
                    end else begin
                        res_vld = 1'b1;
                        n_count = r_count - CNT_W'(1);
                        n_state = S_IDLE;
                    end
                end else if (r_idx == '0) begin
                    res_vld    = 1'b1;
                    res.status = ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    req.re    = 1'b1;
                    req.raddr = r_idx - PTR_W'(1);
                    n_idx     = r_idx - PTR_W'(1);
                end
            end
            S_SHIFT: begin
                // entry r_idx+1 is on the read port; move it down
                req.we    = 1'b1;
                req.waddr = r_idx;
                req.wdata = i_rd_data;
                if ((CNT_W'(r_idx) + CNT_W'(2)) < r_count) begin
                    req.re    = 1'b1;
                    req.raddr = r_idx + PTR_W'(2);
                    n_idx     = r_idx + PTR_W'(1);
                end else begin
                    res_vld = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_val <= n_val;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_mem_req = req;
    assign o_res_vld = res_vld;
    assign o_res     = res;

endmodule

### hw/rtl/swrbv_chk.sv
`include "stack_with_remove_by_value_core_assert.svh"

module swrbv_chk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             o_strobe,
    input  swrbv_pkg::t_res  o_result
);

    import swrbv_pkg::*;

    logic accept;

    assign accept = start && !busy;

    `SWRBV_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, accept, busy || o_strobe, "accepted command neither busy nor answered")
    `SWRBV_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result beat while busy")
    `SWRBV_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, o_strobe, o_result.occupancy <= OCC_W'(DEPTH), "occupancy above capacity")
    `SWRBV_ASSERT_NOW(a_empty_occ, i_clk, i_rst_n, o_strobe && (o_result.status == ST_EMPTY), o_result.occupancy == '0, "empty status with nonzero occupancy")
    `SWRBV_ASSERT_NOW(a_rdval_ok, i_clk, i_rst_n, o_strobe && (o_result.read_value != '0), o_result.status == ST_OK, "read value on failed command")

endmodule

bind stack_with_remove_by_value_core swrbv_chk u_chk (.*);

### dv/tb_stack_with_remove_by_value_core.sv
module tb_stack_with_remove_by_value_core;

    import swrbv_pkg::*;

    // Unused opcode: the block treats it as a no-op that reports the count.
    localparam logic [1:0] OP_NOP = 2'd3;

    // No beat in either direction for this many cycles means the block hung.
    // The slowest remove and the largest send gap both stay far below it,
    // so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 4;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_cmd  i_cmd = '0;
    logic  busy;
    logic  o_strobe;
    t_res  o_result;

    stack_with_remove_by_value_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stack predictor: a plain copy of the stack, updated once per accepted
    // command beat, in command order.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] stack_words [DEPTH];
    int                       stack_count = 0;

    // Results still owed by the block, oldest first.
    t_res expected_results [$];

    int mismatch_count = 0;
    int stall_cycles = 0;

    // Send gap style: 0 back to back, 1 long random gaps, 2 short gaps.
    int idle_mode = 1;

    function automatic t_res stack_apply(input t_cmd c);
        t_res r;
        int   hit;
        r.read_value = '0;
        r.status     = ST_OK;
        case (c.operation)
            OP_PUSH: begin
                if (stack_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_words[stack_count] = c.value;
                    stack_count++;
                end
            end
            OP_POP: begin
                if (stack_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stack_count--;
                    r.read_value = stack_words[stack_count];
                end
            end
            OP_REMOVE: begin
                // Topmost match wins; everything above it slides down one.
                hit = -1;
                for (int k = stack_count - 1; k >= 0; k--) begin
                    if (hit < 0 && stack_words[k] == c.value)
                        hit = k;
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int j = hit; j < stack_count - 1; j++)
                        stack_words[j] = stack_words[j + 1];
                    stack_count--;
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(stack_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side. start is only lowered when a gap is actually taken, so
    // a back-to-back beat never sees start dropped and raised in one step.
    // The beat is taken at the first edge where start is high and busy low;
    // busy is read right after the edge, i.e. its value at the edge.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
        int   gap;
        t_cmd c;
        c.operation = op;
        c.value     = val;
        case (idle_mode)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 18);
            default: gap = $urandom_range(0, 3);
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(stack_apply(c));
    endtask

    // Park the command side and wait until every result beat is back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Operand mix: full-range words, a tight cluster so duplicates and
    // remove hits are common, and the corner words.
    function automatic logic signed [DATA_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            return $urandom;
        if (sel <= 7)
            return $signed($urandom_range(0, 7)) - 4;
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    // Remove operand: mostly a word that is on the stack, so the search and
    // shift paths get real work; otherwise anything, mostly absent.
    function automatic logic signed [DATA_W-1:0] pick_remove_word();
        if (stack_count > 0 && $urandom_range(0, 9) < 6)
            return stack_words[$urandom_range(0, stack_count - 1)];
        return pick_word();
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-stack cases, corner words, duplicates, remove at top, middle and
    // bottom, absent value, the unused opcode, and pop back to empty.
    task automatic test_directed();
        idle_mode = 1;
        send_cmd(OP_POP, 0);
        send_cmd(OP_REMOVE, 0);
        send_cmd(OP_NOP, 32'sh7fff_ffff);
        send_cmd(OP_PUSH, 32'sh8000_0000);
        send_cmd(OP_PUSH, 32'sh7fff_ffff);
        send_cmd(OP_PUSH, 0);
        send_cmd(OP_PUSH, -1);
        send_cmd(OP_PUSH, 5);
        send_cmd(OP_PUSH, 7);
        send_cmd(OP_PUSH, 5);
        send_cmd(OP_NOP, -1);
        send_cmd(OP_REMOVE, 5);              // duplicate: topmost copy goes
        send_cmd(OP_REMOVE, 7);              // match at the top, nothing shifts
        send_cmd(OP_REMOVE, 32'sh8000_0000); // bottom entry, longest shift
        send_cmd(OP_REMOVE, 1234);           // absent on a non-empty stack
        send_cmd(OP_REMOVE, -1);             // match in the middle
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);                 // empty again
        send_cmd(OP_NOP, 0);
        wait_drained();
    endtask

    // Fill past capacity, remove the bottom word's value on a full stack
    // (worst case unless a copy sits higher), refill, then pop everything plus one.
    task automatic test_fill_and_drain();
        idle_mode = 2;
        for (int n = 0; n <= DEPTH; n++)
            send_cmd(OP_PUSH, pick_word());
        send_cmd(OP_NOP, 0);
        send_cmd(OP_REMOVE, stack_words[0]);
        send_cmd(OP_PUSH, $urandom);
        send_cmd(OP_PUSH, $urandom);
        for (int n = 0; n <= DEPTH; n++)
            send_cmd(OP_POP, $urandom);
        wait_drained();
    endtask

    // Blocks of 100 commands. Each block picks a bias (growing, balanced,
    // shrinking) so the stack wanders between empty and full, and a gap
    // style so some blocks run back to back with no idle cycles at all.
    task automatic test_random_traffic();
        int bias;
        int roll;
        for (int blk = 0; blk < 16; blk++) begin
            bias      = $urandom_range(0, 2);
            idle_mode = $urandom_range(0, 2);
            for (int n = 0; n < 100; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    send_cmd(OP_NOP, $urandom);
                else if (roll < (bias == 0 ? 65 : bias == 1 ? 45 : 25))
                    send_cmd(OP_PUSH, pick_word());
                else if (roll < (bias == 0 ? 78 : bias == 1 ? 70 : 60))
                    send_cmd(OP_POP, $urandom);
                else
                    send_cmd(OP_REMOVE, pick_remove_word());
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result side: the receiver cannot stall, so every strobe is a beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing outstanding: read_value %0d status %0d occupancy %0d",
                       o_result.read_value, o_result.status, o_result.occupancy);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, o_result.read_value);
                    mismatch_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    mismatch_count++;
                end
                if (o_result.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, o_result.occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang detector: any command or result beat restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_drain();
        test_random_traffic();

        // Nothing is owed now; give the block time to show any stray beat.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
